/* rtl/core/intel_hex_data_extractor_top_defines.svh */
// Assertion macros for the Intel HEX data extractor.
// Used by intel_hex_data_extractor_top; no other dependencies.
`ifndef INTEL_HEX_DATA_EXTRACTOR_TOP_DEFINES_SVH
`define INTEL_HEX_DATA_EXTRACTOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define IHDE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define IHDE_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define IHDE_ASSERT(label, prop, msg)
`define IHDE_NEVER(label, cond, msg)
`endif

`endif

/* rtl/core/ihde_pkg.sv */
// Package for the Intel HEX data extractor: character codes, line positions
// and the hex digit decode functions. No dependencies.
`default_nettype none

package ihde_pkg;

	typedef logic [3:0] pos_t;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;

	// Place in the current line.
	localparam pos_t POS_START   = 4'd0;
	localparam pos_t POS_LEN_HI  = 4'd1;
	localparam pos_t POS_LEN_LO  = 4'd2;
	localparam pos_t POS_TYPE_HI = 4'd7;
	localparam pos_t POS_TYPE_LO = 4'd8;
	localparam pos_t POS_DATA_HI = 4'd9;
	localparam pos_t POS_DATA_LO = 4'd10;

	// Nibble in bits 3..0, bit 4 set when the character is not a hex digit.
	function automatic logic [4:0] decode_digit(input logic [7:0] c);
		logic [4:0] d;
		if (c >= CH_0 && c <= CH_9) begin
			d = {1'b0, c[3:0]};
		end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
			// Letters A..F sit at low nibble 1..6 in both cases.
			d = {1'b0, 4'(c[3:0] + 4'd9)};
		end else begin
			d = 5'h10;
		end
		return d;
	endfunction

	// Byte in bits 7..0, bit 8 set when either digit was bad.
	function automatic logic [8:0] combine_pair(input logic [4:0] hi, input logic [4:0] lo);
		logic [3:0] h;
		logic [7:0] b;
		h = hi[4] ? 4'hF : hi[3:0];
		b = lo[4] ? 8'hFF : {h, lo[3:0]};
		return {hi[4] | lo[4], b};
	endfunction

endpackage

`default_nettype wire

/* rtl/core/intel_hex_data_extractor_top.sv */
// Intel HEX data extractor: one ASCII character per item in, one decoded
// type 0 data byte per item out. A byte is written to the output register
// (the skid register on an output stall) as its low digit is accepted.
// Throughput: one character per cycle while the skid is empty, set by the
// single decode step; the skid keeps input ready high through one output stall.
// Reset (arst_n low) clears line state, output and skid valid flags.
`default_nettype none
`include "intel_hex_data_extractor_top_defines.svh"

module intel_hex_data_extractor_top
	import ihde_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_in
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] data_byte
	output logic            m_tuser    // [0] bad_digit
);

	pos_t       pos_q, pos_d;
	logic       active_q, active_d;
	logic [7:0] len_q, len_d;
	logic       len_bad_q, len_bad_d;
	logic       type_ok_q, type_ok_d;
	logic [4:0] hi_q, hi_d;
	logic [7:0] bytes_q, bytes_d;

	logic       accept;
	logic [4:0] digit;
	logic [8:0] pair;
	logic       data_open;
	logic       res_valid;

	logic       out_valid_q, skid_valid_q;
	logic [8:0] out_data_q, skid_data_q;

	assign accept = s_tvalid && s_tready;
	assign digit  = decode_digit(s_tdata);
	assign pair   = combine_pair(hi_q, digit);
	assign data_open = type_ok_q && !len_bad_q && (bytes_q < len_q);

	always_comb begin
		pos_d     = pos_q;
		active_d  = active_q;
		len_d     = len_q;
		len_bad_d = len_bad_q;
		type_ok_d = type_ok_q;
		hi_d      = hi_q;
		bytes_d   = bytes_q;
		res_valid = 1'b0;
		if (accept) begin
			if (s_tdata == CH_NEWLINE) begin
				pos_d    = POS_START;
				active_d = 1'b0;
				bytes_d  = '0;
			end else if (pos_q == POS_START) begin
				active_d = (s_tdata == CH_COLON);
				bytes_d  = '0;
				pos_d    = POS_LEN_HI;
			end else if (active_q) begin
				case (pos_q) inside
					POS_LEN_HI, POS_TYPE_HI: begin
						hi_d  = digit;
						pos_d = 4'(pos_q + 4'd1);
					end
					POS_LEN_LO: begin
						len_d     = pair[7:0];
						len_bad_d = pair[8];
						pos_d     = 4'(pos_q + 4'd1);
					end
					POS_TYPE_LO: begin
						// Only a clean type 00 opens the data field.
						type_ok_d = (pair == 9'd0);
						pos_d     = POS_DATA_HI;
					end
					POS_DATA_HI: begin
						if (data_open) begin
							hi_d  = digit;
							pos_d = POS_DATA_LO;
						end
					end
					POS_DATA_LO: begin
						if (data_open) begin
							res_valid = 1'b1;
							bytes_d   = 8'(bytes_q + 8'd1);
							pos_d     = POS_DATA_HI;
						end
					end
					default: begin
						pos_d = 4'(pos_q + 4'd1);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_START;
			active_q  <= 1'b0;
			len_q     <= '0;
			len_bad_q <= 1'b0;
			type_ok_q <= 1'b0;
			hi_q      <= '0;
			bytes_q   <= '0;
		end else begin
			pos_q     <= pos_d;
			active_q  <= active_d;
			len_q     <= len_d;
			len_bad_q <= len_bad_d;
			type_ok_q <= type_ok_d;
			hi_q      <= hi_d;
			bytes_q   <= bytes_d;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : pair;
		end else if (res_valid) begin
			skid_data_q <= pair;
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q[7:0];
	assign m_tuser  = out_data_q[8];

	`IHDE_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds an item while output is empty")
	`IHDE_ASSERT(a_pos_range, pos_q <= POS_DATA_LO, "line position out of range")
	`IHDE_ASSERT(a_emit_in_length, res_valid |-> (bytes_q < len_q) && type_ok_q, "byte emitted beyond record length")
	`IHDE_ASSERT(a_idle_line, (!active_q && pos_q != POS_START) |-> pos_q == POS_LEN_HI, "non-record line advanced its position")

endmodule

`default_nettype wire
